FILE: src/pds_pkg.sv
package pds_pkg;

  // Default widths of the request and of the feedback divider.
  localparam int FREQ_BITS_DEF     = 16;
  localparam int FEEDBACK_BITS_DEF = 11;

  // Fixed field widths.
  localparam int CFG_FREQ_BITS  = 16;
  localparam int REF_DIV_BITS   = 10;
  localparam int CTRL_BITS      = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int POST_CODE_BITS = 3;
  localparam int PDIV_BITS      = 5;
  localparam int OUT_FREQ_BITS  = 20;
  localparam int DIV_WORD_BITS  = 19;
  localparam int SEARCH_BITS    = 20;

  localparam int POST_CODE_SHIFT     = 16;
  localparam int PATH_ENABLE_BIT     = 2;
  localparam int WIDE_SOURCE_SHIFT   = 10;
  localparam int NARROW_SOURCE_SHIFT = 13;
  localparam int XFORM_SOURCE_SHIFT  = 12;

  // Source codes of the DVO routing field.
  localparam logic [1:0] SRC_SECOND_CRTC = 2'd1;
  localparam logic [1:0] SRC_INDIRECT    = 2'd3;

  // Post dividers in search order; the index is the programmed code.
  localparam int NUM_POST = 8;
  localparam logic [PDIV_BITS-1:0] PDIV_TABLE [NUM_POST] = '{
    5'd1, 5'd2, 5'd4, 5'd8, 5'd3, 5'd16, 5'd6, 5'd12
  };

  // Low clamp divides by 12: x * 43691 >> 19 is exact for 16-bit x.
  localparam int MIN_CLAMP_MUL            = 12;
  localparam logic [16:0] DIV12_RECIP     = 17'd43691;
  localparam int DIV12_SHIFT              = 19;

  localparam int QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [CFG_FREQ_BITS-1:0] RST_PLL_MAX = 16'd35000;
  localparam logic [CFG_FREQ_BITS-1:0] RST_PLL_MIN = 16'd12000;
  localparam logic [REF_DIV_BITS-1:0]  RST_REF_DIV = 10'd12;
  localparam logic [CFG_FREQ_BITS-1:0] RST_REF_CLK = 16'd2700;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PLL_MAX_FREQ       = 3'd0,
    REG_PLL_MIN_FREQ       = 3'd1,
    REG_REFERENCE_DIVIDER  = 3'd2,
    REG_REFERENCE_CLOCK    = 3'd3,
    REG_HAS_SECOND_CRTC    = 3'd4,
    REG_WIDE_SOURCE_FORMAT = 3'd5
  } cfg_reg_t;

  // The PLL limit frequencies are kept already masked to the request width.
  typedef struct packed {
    logic [CFG_FREQ_BITS-1:0] pll_max_freq;
    logic [CFG_FREQ_BITS-1:0] pll_min_freq;
    logic [CFG_FREQ_BITS-1:0] min_div12;
    logic [REF_DIV_BITS-1:0]  reference_divider;
    logic [CFG_FREQ_BITS-1:0] reference_clock;
    logic                     has_second_crtc;
    logic                     wide_source_format;
  } cfg_t;

  // Classified request handed from the front end to the divider pipeline.
  typedef struct packed {
    logic [CFG_FREQ_BITS-1:0]  outf;
    logic [POST_CODE_BITS-1:0] code;
    logic                      dvo;
  } cls_t;

endpackage

FILE: src/pds_if.sv
interface pds_in_if import pds_pkg::*; #(parameter int FREQ_BITS = FREQ_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [FREQ_BITS-1:0] target_freq;
  logic [CTRL_BITS-1:0] fp2_control;
  logic [CTRL_BITS-1:0] output_control;

  modport source(output valid, target_freq, fp2_control, output_control, input ready);
  modport sink(input valid, target_freq, fp2_control, output_control, output ready);
endinterface

interface pds_out_if import pds_pkg::*; #(parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEF);
  logic                      valid;
  logic                      ready;
  logic [REF_DIV_BITS-1:0]   ref_div_out;
  logic [FEEDBACK_BITS-1:0]  feedback_div;
  logic [POST_CODE_BITS-1:0] pdiv_code;
  logic [DIV_WORD_BITS-1:0]  divider_word;
  logic [OUT_FREQ_BITS-1:0]  pll_out_freq;
  logic                      dvo_on_primary;
  logic                      feedback_overflow;

  modport source(output valid, ref_div_out, feedback_div, pdiv_code, divider_word,
                 pll_out_freq, dvo_on_primary, feedback_overflow, input ready);
  modport sink(input valid, ref_div_out, feedback_div, pdiv_code, divider_word,
               pll_out_freq, dvo_on_primary, feedback_overflow, output ready);
endinterface

interface pds_cfg_if import pds_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/pds_cfg.sv
module pds_cfg import pds_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  pds_cfg_if.sink cfg_if,
  output cfg_t   cfg
);

  localparam logic [CFG_FREQ_BITS-1:0] FMASK = (FREQ_BITS >= CFG_FREQ_BITS) ?
    {CFG_FREQ_BITS{1'b1}} : CFG_FREQ_BITS'((32'd1 << FREQ_BITS) - 32'd1);
  localparam logic [CFG_FREQ_BITS-1:0] RST_MIN_M = RST_PLL_MIN & FMASK;
  localparam logic [CFG_FREQ_BITS-1:0] RST_MIN_DIV =
    CFG_FREQ_BITS'(RST_MIN_M / MIN_CLAMP_MUL);

  cfg_t                     cfg_r;
  cfg_t                     cfg_nxt;
  logic [CFG_FREQ_BITS-1:0] data_m;
  logic [32:0]              div12_prod;

  assign cfg_if.ready = 1'b1;
  assign data_m       = cfg_if.data & FMASK;
  assign div12_prod   = 33'(data_m) * 33'(DIV12_RECIP);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_PLL_MAX_FREQ: cfg_nxt.pll_max_freq = data_m;
        REG_PLL_MIN_FREQ: begin
          cfg_nxt.pll_min_freq = data_m;
          cfg_nxt.min_div12    = CFG_FREQ_BITS'(div12_prod >> DIV12_SHIFT);
        end
        REG_REFERENCE_DIVIDER:  cfg_nxt.reference_divider  = cfg_if.data[REF_DIV_BITS-1:0];
        REG_REFERENCE_CLOCK:    cfg_nxt.reference_clock    = cfg_if.data;
        REG_HAS_SECOND_CRTC:    cfg_nxt.has_second_crtc    = cfg_if.data[0];
        REG_WIDE_SOURCE_FORMAT: cfg_nxt.wide_source_format = cfg_if.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pll_max_freq       <= RST_PLL_MAX & FMASK;
      cfg_r.pll_min_freq       <= RST_MIN_M;
      cfg_r.min_div12          <= RST_MIN_DIV;
      cfg_r.reference_divider  <= RST_REF_DIV;
      cfg_r.reference_clock    <= RST_REF_CLK;
      cfg_r.has_second_crtc    <= 1'b1;
      cfg_r.wide_source_format <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/pds_front.sv
module pds_front import pds_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  pds_in_if.sink  in_if,
  input  cfg_t    cfg,
  input  logic    q_full,
  output logic    push,
  output cls_t    push_data
);

  localparam int EW = (FREQ_BITS > CFG_FREQ_BITS) ? FREQ_BITS : CFG_FREQ_BITS;

  // Stage 1: clamp and DVO routing.
  logic                     s1_v_r;
  logic [CFG_FREQ_BITS-1:0] s1_freq_r;
  logic                     s1_dvo_r;
  logic [CFG_FREQ_BITS-1:0] s1_freq_nxt;
  logic                     s1_dvo_nxt;

  logic [EW-1:0]            freq_e;
  logic [CFG_FREQ_BITS-1:0] clamp_hi;
  logic [SEARCH_BITS-1:0]   clamp_x12;
  logic [1:0]               src;

  // Stage 2: post divider search.
  logic [SEARCH_BITS-1:0]    prod [NUM_POST];
  logic [NUM_POST-1:0]       fits;
  logic                      found;
  logic [POST_CODE_BITS-1:0] code;

  assign in_if.ready = !s1_v_r || !q_full;
  assign freq_e      = EW'(in_if.target_freq);

  always_comb begin
    clamp_hi  = (freq_e > EW'(cfg.pll_max_freq)) ? cfg.pll_max_freq
                                                 : freq_e[CFG_FREQ_BITS-1:0];
    clamp_x12 = (SEARCH_BITS'(clamp_hi) << 3) + (SEARCH_BITS'(clamp_hi) << 2);
    s1_freq_nxt = (clamp_x12 < SEARCH_BITS'(cfg.pll_min_freq)) ? cfg.min_div12 : clamp_hi;

    // Wide format: source code 3 defers to the transform unit's source.
    if (cfg.wide_source_format) begin
      src = in_if.fp2_control[WIDE_SOURCE_SHIFT +: 2];
      if (src == SRC_INDIRECT) begin
        src = in_if.output_control[XFORM_SOURCE_SHIFT +: 2];
      end
    end else begin
      src = {1'b0, in_if.fp2_control[NARROW_SOURCE_SHIFT]};
    end
    s1_dvo_nxt = cfg.has_second_crtc && in_if.fp2_control[PATH_ENABLE_BIT] &&
                 (src != SRC_SECOND_CRTC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_freq_r <= s1_freq_nxt;
      s1_dvo_r  <= s1_dvo_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_POST; i++) begin
      prod[i] = SEARCH_BITS'(s1_freq_r) * SEARCH_BITS'(PDIV_TABLE[i]);
      fits[i] = !(s1_dvo_r && PDIV_TABLE[i][0]) &&
                (prod[i] >= SEARCH_BITS'(cfg.pll_min_freq)) &&
                (prod[i] <= SEARCH_BITS'(cfg.pll_max_freq));
    end
    // First fitting divider in table order wins.
    found = 1'b0;
    code  = '0;
    for (int i = NUM_POST - 1; i >= 0; i--) begin
      if (fits[i]) begin
        found = 1'b1;
        code  = POST_CODE_BITS'(i);
      end
    end
  end

  assign push           = s1_v_r && !q_full;
  assign push_data.code = code;
  assign push_data.dvo  = s1_dvo_r;
  assign push_data.outf = found ? prod[code][CFG_FREQ_BITS-1:0] : s1_freq_r;

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && q_full |=> s1_v_r && $stable(s1_freq_r) && $stable(s1_dvo_r))
    else $error("front stage lost a word while the queue was full");

  a_dvo_even: assert property (@(posedge clk) disable iff (!rst_n)
    push && found && s1_dvo_r |-> !PDIV_TABLE[code][0])
    else $error("odd post divider chosen on the DVO path");

endmodule

FILE: src/pds_queue.sv
module pds_queue import pds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cls_t pop_data
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  cls_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                do_pop;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_ONE;
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> count_r == $past(count_r) + CNT_ONE)
    else $error("queue count did not follow a lone push");

endmodule

FILE: src/pds_back.sv
module pds_back import pds_pkg::*; #(
  parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cls_t      q_data,
  output logic      q_pop,
  pds_out_if.source out_if
);

  // Stage 0 multiplies, stage 1 rounds and checks overflow, then one
  // quotient bit per stage.
  localparam int FB    = FEEDBACK_BITS;
  localparam int NS    = FB + 2;
  localparam int PRODW = REF_DIV_BITS + CFG_FREQ_BITS;
  localparam int NUMW  = PRODW + 1;
  localparam int RW    = CFG_FREQ_BITS + FB;
  localparam int PW    = (NUMW > RW) ? NUMW : RW;
  localparam int L     = NS - 1;

  typedef struct packed {
    logic [PW-1:0]             rem;
    logic [FB-1:0]             quo;
    logic                      ovf;
    logic [CFG_FREQ_BITS-1:0]  outf;
    logic [POST_CODE_BITS-1:0] code;
    logic                      dvo;
  } bk_t;

  bk_t                      st_r   [NS];
  bk_t                      st_nxt [NS];
  logic [NS-1:0]            v_r;
  logic                     adv;
  logic [PRODW-1:0]         prod;
  logic [FB-1:0]            fb;
  logic [DIV_WORD_BITS-1:0] word;

  // The whole pipeline moves together; the queue absorbs output stalls.
  assign adv   = !v_r[L] || out_if.ready;
  assign q_pop = adv && q_valid;
  assign prod  = PRODW'(cfg.reference_divider) * PRODW'(q_data.outf);

  always_comb begin
    logic [PW-1:0] dsh;
    logic [PW-1:0] num;

    st_nxt[0].rem  = PW'(prod);
    st_nxt[0].quo  = '0;
    st_nxt[0].ovf  = 1'b0;
    st_nxt[0].outf = q_data.outf;
    st_nxt[0].code = q_data.code;
    st_nxt[0].dvo  = q_data.dvo;

    // A zero reference clock makes the limit zero, so it reports overflow.
    num            = st_r[0].rem + PW'(cfg.reference_clock[CFG_FREQ_BITS-1:1]);
    st_nxt[1]      = st_r[0];
    st_nxt[1].rem  = num;
    st_nxt[1].ovf  = num >= (PW'(cfg.reference_clock) << FB);

    for (int j = 0; j < FB; j++) begin
      dsh           = PW'(cfg.reference_clock) << (FB - 1 - j);
      st_nxt[j + 2] = st_r[j + 1];
      if (st_r[j + 1].rem >= dsh) begin
        st_nxt[j + 2].rem          = st_r[j + 1].rem - dsh;
        st_nxt[j + 2].quo[FB-1-j]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign fb   = st_r[L].ovf ? {FB{1'b1}} : st_r[L].quo;
  assign word = DIV_WORD_BITS'(fb) | (DIV_WORD_BITS'(st_r[L].code) << POST_CODE_SHIFT);

  assign out_if.valid             = v_r[L];
  assign out_if.ref_div_out       = cfg.reference_divider;
  assign out_if.feedback_div      = fb;
  assign out_if.pdiv_code         = st_r[L].code;
  assign out_if.divider_word      = word;
  assign out_if.pll_out_freq      = OUT_FREQ_BITS'(st_r[L].outf);
  assign out_if.dvo_on_primary    = st_r[L].dvo;
  assign out_if.feedback_overflow = st_r[L].ovf;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L] && !st_r[L].ovf |-> st_r[L].rem < PW'(cfg.reference_clock))
    else $error("division remainder not below the reference clock");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !adv |=> v_r[0] && $stable(st_r[0]))
    else $error("multiply stage changed while the pipeline was stalled");

endmodule

FILE: src/pll_divider_select_unit.sv
// PLL divider selection for a requested pixel clock.
//
// in_if takes one request word: target frequency and the two raw output
// control words. out_if gives one result word per request, in order:
// reference, feedback and post divider, the packed divider word, the chosen
// PLL output frequency, the DVO routing flag and the feedback overflow flag.
// cfg_if writes the six configuration registers by index; it is always
// ready and should be used only while no request is in flight.
// A request is accepted every cycle unless the queue and the front register
// are both full. It passes through the clamp, the post divider search and
// queue write, the multiply and the rounding, then one quotient bit of the
// feedback division per pipeline stage.
// Reset loads the register defaults and empties the pipeline; no clearing
// pass is needed. When the receiver stalls, the result word holds and the
// divider pipeline freezes; the front end keeps taking requests until the
// four-entry queue and its own register are full.
module pll_divider_select_unit import pds_pkg::*; #(
  parameter int FREQ_BITS     = FREQ_BITS_DEF,
  parameter int FEEDBACK_BITS = FEEDBACK_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pds_cfg_if.sink    cfg_if,
  pds_in_if.sink     in_if,
  pds_out_if.source  out_if
);

  cfg_t cfg;
  logic push;
  cls_t push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cls_t q_data;

  pds_cfg #(
    .FREQ_BITS(FREQ_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  pds_front #(
    .FREQ_BITS(FREQ_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  pds_back #(
    .FEEDBACK_BITS(FEEDBACK_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
